// ===== hw/rtl/wtdr_pkg.sv =====
// ----------------------------------------------------------------------------
// wtdr_pkg: shared definitions for the wireframe triangle rasterizer
// Widths, command and edge codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package wtdr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WIDTH_BITS     = 11;
    localparam int ADDR_BITS      = 20;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_PIXEL
    } wtdr_state_t;

endpackage

// ===== hw/rtl/wtdr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// wtdr_cmd_if: command channel of the wireframe triangle rasterizer
// Carries load and step commands with the three vertices of a triangle.
// ----------------------------------------------------------------------------
interface wtdr_cmd_if #(
    parameter int COORD_BITS = wtdr_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] vertex_a_x;
    logic [COORD_BITS-1:0] vertex_a_y;
    logic [COORD_BITS-1:0] vertex_b_x;
    logic [COORD_BITS-1:0] vertex_b_y;
    logic [COORD_BITS-1:0] vertex_c_x;
    logic [COORD_BITS-1:0] vertex_c_y;

    modport source (
        output valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        input  ready
    );

    modport sink (
        input  valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        output ready
    );
endinterface

// ===== hw/rtl/wtdr_pix_if.sv =====
// ----------------------------------------------------------------------------
// wtdr_pix_if: pixel channel of the wireframe triangle rasterizer
// Carries one outline pixel per beat with its framebuffer address.
// ----------------------------------------------------------------------------
interface wtdr_pix_if #(
    parameter int COORD_BITS = wtdr_pkg::COORD_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic [COORD_BITS-1:0]          pixel_x;
    logic [COORD_BITS-1:0]          pixel_y;
    logic [wtdr_pkg::ADDR_BITS-1:0] pixel_address;
    logic [1:0]                     edge_number;
    logic                           last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, edge_number, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, edge_number, last_pixel,
        output ready
    );
endinterface

// ===== hw/rtl/wireframe_triangle_dda_rasterizer.sv =====
// ----------------------------------------------------------------------------
// wireframe_triangle_dda_rasterizer: pull-driven DDA triangle outline walker
// A load beat on cmd stores three vertices; each step beat returns the next
// outline pixel on pix. Edges a-b, b-c and c-a are walked in that order.
// Usage: cfg_we/cfg_wdata set the screen width used for pixel_address; write
// it only while the block is idle. A load beat gives no pixel. It is followed
// by the edge setup: S_SETUP forms the deltas and the length, then one shared
// restoring divider computes the x and then the y step, one quotient bit per
// cycle, so cmd.ready stays low after the load until both steps are set,
// or only in S_SETUP if the edge has zero length and the divider is skipped.
// A step beat inside an edge is accepted in S_IDLE; S_PIXEL then rounds
// the position, multiplies the row by the width and fills the output
// register, which drives pix. The step that returns the endpoint of edge
// a-b or b-c also runs the setup of the next edge; c-a ends the triangle.
// A step while no triangle is active is consumed and gives no pixel.
// pix is held in an output register, so a new command is accepted while a
// pixel waits; a pixel cycle waits until the output register is free.
// Reset clears the vertices, the walker and the width, and leaves it idle.
// ----------------------------------------------------------------------------
module wireframe_triangle_dda_rasterizer #(
    parameter int COORD_BITS = wtdr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = wtdr_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wtdr_pkg::WIDTH_BITS-1:0] cfg_wdata,
    wtdr_cmd_if.sink                        cmd,
    wtdr_pix_if.source                      pix
);
    import wtdr_pkg::*;

    localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int PROD_W = COORD_BITS + WIDTH_BITS;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;
    localparam logic [POS_W-1:0] HALF_FIX =
        {{(POS_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    wtdr_state_t state_reg, state_next;

    logic [COORD_BITS-1:0]    vx_reg [3];
    logic [COORD_BITS-1:0]    vy_reg [3];
    logic [COORD_BITS-1:0]    vx_next [3];
    logic [COORD_BITS-1:0]    vy_next [3];
    logic signed [POS_W-1:0]  pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [COORD_BITS-1:0]    steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0]    len_reg, len_next;
    logic [COORD_BITS-1:0]    mag_y_reg, mag_y_next;
    logic                     neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [COORD_BITS:0]      rem_reg, rem_next;
    logic [FRAC_BITS:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     div_y_reg, div_y_next;
    logic [1:0]               edge_reg, edge_next;
    logic                     busy_reg, busy_next;
    logic [WIDTH_BITS-1:0]    line_width_reg;

    logic                     pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0]    pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic [ADDR_BITS-1:0]     pix_addr_reg, pix_addr_next;
    logic [1:0]               pix_edge_reg, pix_edge_next;
    logic                     pix_last_reg, pix_last_next;
    logic                     pix_load;

    logic                     cmd_fire;
    logic                     out_free;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]    abs_dx, abs_dy, len_calc;
    logic [COORD_BITS:0]      trial, diff;
    logic                     ge;
    logic [FRAC_BITS:0]       quo_final;
    logic signed [STEP_W-1:0] step_mag, step_val;
    logic [POS_W-1:0]         rnd_x, rnd_y;
    logic [COORD_BITS-1:0]    px_sel, py_sel;
    logic [PROD_W-1:0]        prod;
    logic [SUM_W-1:0]         addr_sum;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !pix_valid_reg || pix.ready;

    assign pix.valid         = pix_valid_reg;
    assign pix.pixel_x       = pix_x_reg;
    assign pix.pixel_y       = pix_y_reg;
    assign pix.pixel_address = pix_addr_reg;
    assign pix.edge_number   = pix_edge_reg;
    assign pix.last_pixel    = pix_last_reg;

    // Edge setup: slot 0 always holds the start vertex and slot 1 the end.
    assign dx     = $signed({1'b0, vx_reg[1]}) - $signed({1'b0, vx_reg[0]});
    assign dy     = $signed({1'b0, vy_reg[1]}) - $signed({1'b0, vy_reg[0]});
    assign abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    assign len_calc = (abs_dx > abs_dy) ? abs_dx : abs_dy;

    // Shared divider: one quotient bit per cycle; the first bit is the
    // integer bit, taken without a shift.
    assign trial     = (cnt_reg == '0) ? rem_reg : {rem_reg[COORD_BITS-1:0], 1'b0};
    assign ge        = trial >= {1'b0, len_reg};
    assign diff      = trial - {1'b0, len_reg};
    assign quo_final = {quo_reg[FRAC_BITS-1:0], ge};
    assign step_mag  = $signed({1'b0, quo_final});
    assign step_val  = (div_y_reg ? neg_y_reg : neg_x_reg) ? -step_mag : step_mag;

    // Pixel datapath: round half up, or the edge endpoint, then the address.
    assign rnd_x    = pos_x_reg + HALF_FIX;
    assign rnd_y    = pos_y_reg + HALF_FIX;
    assign px_sel   = (steps_left_reg != '0) ? rnd_x[FRAC_BITS +: COORD_BITS] : vx_reg[1];
    assign py_sel   = (steps_left_reg != '0) ? rnd_y[FRAC_BITS +: COORD_BITS] : vy_reg[1];
    assign prod     = PROD_W'(py_sel) * PROD_W'(line_width_reg);
    assign addr_sum = SUM_W'(prod) + SUM_W'(px_sel);

    always_comb
    begin
        state_next      = state_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        steps_left_next = steps_left_reg;
        len_next        = len_reg;
        mag_y_next      = mag_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        div_y_next      = div_y_reg;
        edge_next       = edge_reg;
        busy_next       = busy_reg;
        pix_load        = 1'b0;
        pix_valid_next  = pix_valid_reg && !pix.ready;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        pix_addr_next   = pix_addr_reg;
        pix_edge_next   = pix_edge_reg;
        pix_last_next   = pix_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.action == ACT_LOAD)
                    begin
                        vx_next[0] = cmd.vertex_a_x;
                        vy_next[0] = cmd.vertex_a_y;
                        vx_next[1] = cmd.vertex_b_x;
                        vy_next[1] = cmd.vertex_b_y;
                        vx_next[2] = cmd.vertex_c_x;
                        vy_next[2] = cmd.vertex_c_y;
                        edge_next  = EDGE_AB;
                        busy_next  = 1'b1;
                        state_next = S_SETUP;
                    end
                    else if (busy_reg)
                    begin
                        state_next = S_PIXEL;
                    end
                end
            end

            S_SETUP:
            begin
                pos_x_next      = $signed({1'b0, vx_reg[0], {FRAC_BITS{1'b0}}});
                pos_y_next      = $signed({1'b0, vy_reg[0], {FRAC_BITS{1'b0}}});
                steps_left_next = len_calc;
                len_next        = len_calc;
                mag_y_next      = abs_dy;
                neg_x_next      = dx[COORD_BITS];
                neg_y_next      = dy[COORD_BITS];
                rem_next        = {1'b0, abs_dx};
                quo_next        = '0;
                cnt_next        = '0;
                div_y_next      = 1'b0;
                step_x_next     = '0;
                step_y_next     = '0;
                state_next      = (len_calc == '0) ? S_IDLE : S_DIV;
            end

            S_DIV:
            begin
                rem_next = ge ? diff : trial;
                quo_next = quo_final;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    cnt_next = '0;
                    quo_next = '0;
                    if (div_y_reg)
                    begin
                        step_y_next = step_val;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        step_x_next = step_val;
                        div_y_next  = 1'b1;
                        rem_next    = {1'b0, mag_y_reg};
                    end
                end
            end

            S_PIXEL:
            begin
                if (out_free)
                begin
                    pix_load       = 1'b1;
                    pix_valid_next = 1'b1;
                    pix_x_next     = px_sel;
                    pix_y_next     = py_sel;
                    pix_addr_next  = addr_sum[ADDR_BITS-1:0];
                    pix_edge_next  = edge_reg;
                    pix_last_next  = 1'b0;
                    if (steps_left_reg != '0)
                    begin
                        pos_x_next      = pos_x_reg + POS_W'(step_x_reg);
                        pos_y_next      = pos_y_reg + POS_W'(step_y_reg);
                        steps_left_next = steps_left_reg - 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (edge_reg == EDGE_CA)
                    begin
                        pix_last_next = 1'b1;
                        busy_next     = 1'b0;
                        edge_next     = EDGE_AB;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        vx_next[0] = vx_reg[1];
                        vy_next[0] = vy_reg[1];
                        vx_next[1] = vx_reg[2];
                        vy_next[1] = vy_reg[2];
                        vx_next[2] = vx_reg[0];
                        vy_next[2] = vy_reg[0];
                        edge_next  = edge_reg + 1'b1;
                        state_next = S_SETUP;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vx_reg         <= '{default: '0};
            vy_reg         <= '{default: '0};
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            steps_left_reg <= '0;
            cnt_reg        <= '0;
            div_y_reg      <= 1'b0;
            edge_reg       <= EDGE_AB;
            busy_reg       <= 1'b0;
            line_width_reg <= '0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vx_reg         <= vx_next;
            vy_reg         <= vy_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            steps_left_reg <= steps_left_next;
            cnt_reg        <= cnt_next;
            div_y_reg      <= div_y_next;
            edge_reg       <= edge_next;
            busy_reg       <= busy_next;
            pix_valid_reg  <= pix_valid_next;
            if (cfg_we)
            begin
                line_width_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        mag_y_reg <= mag_y_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        if (pix_load)
        begin
            pix_x_reg    <= pix_x_next;
            pix_y_reg    <= pix_y_next;
            pix_addr_reg <= pix_addr_next;
            pix_edge_reg <= pix_edge_next;
            pix_last_reg <= pix_last_next;
        end
    end

    // The last pixel of a triangle always belongs to edge c-a.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.last_pixel |-> pix.edge_number == EDGE_CA)
        else $error("last pixel flagged outside edge c-a");

    // Any work in progress belongs to an active triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> busy_reg)
        else $error("sequencer active without a triangle");

    // After the integer bit, the divider remainder stays below the length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg != '0 |-> rem_reg < {1'b0, len_reg})
        else $error("divider remainder out of range");

    // Emitting the final endpoint ends the triangle and flags the pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PIXEL && out_free && steps_left_reg == '0 && edge_reg == EDGE_CA
        |=> !busy_reg && pix.valid && pix.last_pixel)
        else $error("triangle did not close on its final endpoint");

endmodule
